@@ hw/rtl/rotenc_pkg.sv @@
package rotenc_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int NOW_WIDTH = 32;
   localparam int DEB_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Register indexes, taken from the word address of the configuration port.
   localparam logic REG_TURN_DEBOUNCE = 1'b0;
   localparam logic REG_BUTTON_DEBOUNCE = 1'b1;

   localparam logic [DEB_WIDTH-1:0] TURN_DEBOUNCE_RESET = 16'd1;
   localparam logic [DEB_WIDTH-1:0] BUTTON_DEBOUNCE_RESET = 16'd200;

   // Latched spin codes as reported in the result.
   localparam logic [2:0] SPIN_NONE = 3'd0;
   localparam logic [2:0] SPIN_LEFT = 3'd1;
   localparam logic [2:0] SPIN_RIGHT = 3'd2;
   localparam logic [2:0] SPIN_LEFT_HELD = 3'd3;
   localparam logic [2:0] SPIN_RIGHT_HELD = 3'd4;

   // Both pins idle high.
   localparam logic [1:0] PINS_IDLE = 2'b11;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_LEFT,
      STEP_RIGHT
   } step_type;

   typedef struct packed {
      logic                 pin_a;
      logic                 pin_b;
      logic                 button_n;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 ack_spin;
      logic                 ack_turn;
   } req_type;

   typedef struct packed {
      logic [2:0] spin_code;
      logic       turn_flag;
      logic       click_now;
      logic       held_turn_now;
   } rsp_type;

   // Transition code is {old A, old B, new A, new B}.
   function automatic step_type step_class(input logic [3:0] code);
      step_type kind;
      case (code)
         4'b1101, 4'b0100, 4'b0010, 4'b1011: kind = STEP_LEFT;
         4'b1110, 4'b0111, 4'b0001, 4'b1000: kind = STEP_RIGHT;
         default: kind = STEP_NONE;
      endcase
      return kind;
   endfunction

endpackage

@@ hw/rtl/rotary_encoder_decoder.sv @@
// Quadrature decoder for a rotary encoder with push button. Every request is one sample of
// pins A and B, the active-low button and a millisecond timestamp, and gives exactly one
// result: the latched spin state, the turn-pending flag, and whether a debounced click or a
// step with the button held was accepted on that sample. A step or a press counts only when
// the wrapping time since the last accepted event exceeds its debounce register (registers
// at byte addresses 0 and 4). The block takes one request per clock unless the output stalls,
// and delivers its result in the next cycle; the decoder state is updated as each request is
// taken. A new request is taken when the result register is empty or its result leaves in the
// same cycle, so a result that waits on the output also holds off the input.
module rotary_encoder_decoder #(
   parameter int TIME_WIDTH = rotenc_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rotenc_pkg::req_type                   req_data,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rotenc_pkg::rsp_type                   rsp_data,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rotenc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rotenc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rotenc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                  csr_pready
);

   localparam int CMP_WIDTH = (TIME_WIDTH > rotenc_pkg::DEB_WIDTH) ?
                              TIME_WIDTH : rotenc_pkg::DEB_WIDTH;

   logic [rotenc_pkg::DEB_WIDTH-1:0] turn_deb_ff, turn_deb_in;
   logic [rotenc_pkg::DEB_WIDTH-1:0] button_deb_ff, button_deb_in;

   logic [1:0]            prev_pins_ff, prev_pins_in;
   logic [TIME_WIDTH-1:0] last_time_ff, last_time_in;
   logic [2:0]            spin_latch_ff, spin_latch_in;
   logic                  turn_pending_ff, turn_pending_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rotenc_pkg::rsp_type   rsp_ff, rsp_in;

   logic                  csr_write;
   logic                  accept;
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] delta;
   logic [1:0]            pair;
   rotenc_pkg::step_type  kind;
   logic                  pressed;
   logic                  click;
   logic                  step_ok;
   logic                  pending_mid;
   logic [2:0]            spin_mid;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      turn_deb_in = turn_deb_ff;
      button_deb_in = button_deb_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            rotenc_pkg::REG_TURN_DEBOUNCE: turn_deb_in = csr_pwdata[rotenc_pkg::DEB_WIDTH-1:0];
            rotenc_pkg::REG_BUTTON_DEBOUNCE:
               button_deb_in = csr_pwdata[rotenc_pkg::DEB_WIDTH-1:0];
            default: turn_deb_in = turn_deb_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rotenc_pkg::REG_TURN_DEBOUNCE:
            csr_prdata = rotenc_pkg::CSR_DATA_WIDTH'(turn_deb_ff);
         rotenc_pkg::REG_BUTTON_DEBOUNCE:
            csr_prdata = rotenc_pkg::CSR_DATA_WIDTH'(button_deb_ff);
         default: csr_prdata = '0;
      endcase
   end

   // Handshake: the result register is the only stage.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Decode one sample against the current state.
   assign now_t = (TIME_WIDTH)'(req_data.now_ms);
   assign delta = now_t - last_time_ff;
   assign pair = {req_data.pin_a, req_data.pin_b};
   assign kind = rotenc_pkg::step_class({prev_pins_ff, pair});
   assign pressed = !req_data.button_n;
   assign click = pressed &&
                  ((CMP_WIDTH)'(delta) > (CMP_WIDTH)'(button_deb_ff));
   assign step_ok = (kind != rotenc_pkg::STEP_NONE) &&
                    ((CMP_WIDTH)'(delta) > (CMP_WIDTH)'(turn_deb_ff));

   always_comb begin
      // An accepted step re-arms the turn flag even if a click cleared it.
      pending_mid = step_ok ? 1'b1 : (click ? 1'b0 : turn_pending_ff);
      spin_mid = spin_latch_ff;
      if (step_ok) begin
         case (kind)
            rotenc_pkg::STEP_LEFT:
               spin_mid = pressed ? rotenc_pkg::SPIN_LEFT_HELD : rotenc_pkg::SPIN_LEFT;
            rotenc_pkg::STEP_RIGHT:
               spin_mid = pressed ? rotenc_pkg::SPIN_RIGHT_HELD : rotenc_pkg::SPIN_RIGHT;
            default: spin_mid = spin_latch_ff;
         endcase
      end
   end

   always_comb begin
      prev_pins_in = prev_pins_ff;
      last_time_in = last_time_ff;
      spin_latch_in = spin_latch_ff;
      turn_pending_in = turn_pending_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         prev_pins_in = pair;
         if (click || step_ok) begin
            last_time_in = now_t;
         end
         spin_latch_in = req_data.ack_spin ? rotenc_pkg::SPIN_NONE : spin_mid;
         turn_pending_in = req_data.ack_turn ? 1'b0 : pending_mid;
         rsp_in.spin_code = spin_mid;
         rsp_in.turn_flag = pending_mid;
         rsp_in.click_now = click;
         rsp_in.held_turn_now = step_ok && pressed;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_deb_ff <= rotenc_pkg::TURN_DEBOUNCE_RESET;
         button_deb_ff <= rotenc_pkg::BUTTON_DEBOUNCE_RESET;
         prev_pins_ff <= rotenc_pkg::PINS_IDLE;
         last_time_ff <= '0;
         spin_latch_ff <= rotenc_pkg::SPIN_NONE;
         turn_pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         turn_deb_ff <= turn_deb_in;
         button_deb_ff <= button_deb_in;
         prev_pins_ff <= prev_pins_in;
         last_time_ff <= last_time_in;
         spin_latch_ff <= spin_latch_in;
         turn_pending_ff <= turn_pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_held_sets_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.held_turn_now |-> rsp_ff.turn_flag)
      else $error("held step reported without turn flag");

   a_held_spin_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.held_turn_now |->
         (rsp_ff.spin_code == rotenc_pkg::SPIN_LEFT_HELD ||
          rsp_ff.spin_code == rotenc_pkg::SPIN_RIGHT_HELD))
      else $error("held step reported with a plain spin code");

   a_ack_spin_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.ack_spin |=> spin_latch_ff == rotenc_pkg::SPIN_NONE)
      else $error("spin latch not cleared by acknowledge");

   a_ack_turn_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.ack_turn |=> !turn_pending_ff)
      else $error("turn flag not cleared by acknowledge");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");
`endif

endmodule
